### hw/rtl/epq_pkg.sv
// Shared types, sizes and codes for the event priority queue.
package epq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_W       = 5;
  localparam int KEY_W       = 32;
  localparam int FLD_W       = 16;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_POP    = 2'd1,
    ACT_DELETE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_FINISH
  } state_e;

  // Event body stored next to its key
  typedef struct packed {
    logic [FLD_W-1:0] io_time;
    logic [FLD_W-1:0] cpu_burst;
    logic [FLD_W-1:0] pid;
  } event_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    event_t           ev;
  } entry_t;

  // One request as taken from the input channel
  typedef struct packed {
    logic [1:0]       action;
    logic [KEY_W-1:0] key;
    event_t           ev;
  } cmd_t;

  // One finished result handed to the output stage
  typedef struct packed {
    status_e          status;
    entry_t           entry;
    logic [OCC_W-1:0] occupancy;
  } result_t;

endpackage

### hw/rtl/epq_if.sv
// Valid/ready channel interfaces for the event priority queue.
interface epq_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                action;
  logic [epq_pkg::FLD_W-1:0] pid;
  logic [epq_pkg::KEY_W-1:0] arr_stamp;
  logic [epq_pkg::FLD_W-1:0] cpu_burst;
  logic [epq_pkg::FLD_W-1:0] io_time;

  modport source (output valid, action, pid, arr_stamp, cpu_burst, io_time,
                  input ready);
  modport sink   (input valid, action, pid, arr_stamp, cpu_burst, io_time,
                  output ready);
endinterface

interface epq_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic [epq_pkg::FLD_W-1:0] out_pid;
  logic [epq_pkg::KEY_W-1:0] out_arr_stamp;
  logic [epq_pkg::FLD_W-1:0] out_cpu_burst;
  logic [epq_pkg::FLD_W-1:0] out_io_time;
  logic [epq_pkg::OCC_W-1:0] occupancy;

  modport source (output valid, status, out_pid, out_arr_stamp, out_cpu_burst,
                  out_io_time, occupancy, input ready);
  modport sink   (input valid, status, out_pid, out_arr_stamp, out_cpu_burst,
                  out_io_time, occupancy, output ready);
endinterface

### hw/rtl/epq_core.sv
// Sorted event store and the sequencer that walks it one entry per cycle.
module epq_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  epq_pkg::cmd_t    cmd,
  input  logic             slot_free,
  output logic             idle,
  output logic             res_valid,
  output epq_pkg::result_t res
);

  // Sorted store, one write and one registered read per cycle
  epq_pkg::entry_t mem [epq_pkg::QUEUE_DEPTH];
  epq_pkg::entry_t rd_data;
  logic [epq_pkg::IDX_W-1:0] rd_addr;
  logic [epq_pkg::IDX_W-1:0] wr_addr;
  epq_pkg::entry_t           wr_data;
  logic                      mem_we;

  epq_pkg::state_e           state;
  epq_pkg::state_e           state_next;
  logic [epq_pkg::CNT_W-1:0] count;
  logic [epq_pkg::IDX_W-1:0] proc_idx;
  logic                      found;
  epq_pkg::cmd_t             op;
  epq_pkg::status_e          res_status;
  epq_pkg::entry_t           res_entry;

  logic                      full;
  logic                      empty;
  logic                      greater;
  logic                      hit;
  logic                      last;
  logic                      op_insert;
  epq_pkg::entry_t           new_entry;
  epq_pkg::entry_t           cmd_entry;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Compare terms for the entry now on the read port
  assign full      = (count == epq_pkg::CNT_W'(epq_pkg::QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign op_insert = (op.action == epq_pkg::ACT_INSERT);
  assign greater   = (rd_data.key > op.key);
  assign hit       = (op.action == epq_pkg::ACT_POP) || (rd_data.key == op.key);
  assign last      = (epq_pkg::CNT_W'(proc_idx) == count - epq_pkg::CNT_W'(1));
  assign new_entry = '{key: op.key, ev: op.ev};
  assign cmd_entry = '{key: cmd.key, ev: cmd.ev};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      epq_pkg::S_IDLE: begin
        if (start) begin
          case (cmd.action) inside
            epq_pkg::ACT_INSERT:
              state_next = (full || empty) ? epq_pkg::S_FINISH : epq_pkg::S_SCAN;
            epq_pkg::ACT_POP, epq_pkg::ACT_DELETE:
              state_next = empty ? epq_pkg::S_FINISH : epq_pkg::S_SCAN;
            default:
              state_next = epq_pkg::S_FINISH;
          endcase
        end
      end
      epq_pkg::S_SCAN: begin
        if (op_insert) begin
          if (!greater) begin
            state_next = epq_pkg::S_FINISH;
          end else if (proc_idx == '0) begin
            state_next = epq_pkg::S_PLACE;
          end
        end else if (last) begin
          state_next = epq_pkg::S_FINISH;
        end
      end
      epq_pkg::S_PLACE: begin
        state_next = epq_pkg::S_FINISH;
      end
      epq_pkg::S_FINISH: begin
        if (slot_free) begin
          state_next = epq_pkg::S_IDLE;
        end
      end
      default: state_next = epq_pkg::S_IDLE;
    endcase
  end

  // Store port control
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = '0;
    wr_data = rd_data;
    rd_addr = proc_idx;
    unique case (state)
      epq_pkg::S_IDLE: begin
        // insert walks down from the tail, pop and delete walk up from the head
        rd_addr = (cmd.action == epq_pkg::ACT_INSERT) ?
                  epq_pkg::IDX_W'(count - epq_pkg::CNT_W'(1)) : '0;
        if (start && cmd.action == epq_pkg::ACT_INSERT && empty) begin
          mem_we  = 1'b1;
          wr_data = cmd_entry;
        end
      end
      epq_pkg::S_SCAN: begin
        if (op_insert) begin
          rd_addr = proc_idx - epq_pkg::IDX_W'(1);
          mem_we  = 1'b1;
          wr_addr = proc_idx + epq_pkg::IDX_W'(1);
          wr_data = greater ? rd_data : new_entry;
        end else begin
          rd_addr = proc_idx + epq_pkg::IDX_W'(1);
          if (found) begin
            mem_we  = 1'b1;
            wr_addr = proc_idx - epq_pkg::IDX_W'(1);
          end
        end
      end
      epq_pkg::S_PLACE: begin
        mem_we  = 1'b1;
        wr_data = new_entry;
      end
      epq_pkg::S_FINISH: begin
        rd_addr = proc_idx;
      end
      default: rd_addr = proc_idx;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= epq_pkg::S_IDLE;
      count <= '0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        epq_pkg::S_IDLE: begin
          if (start) begin
            op        <= cmd;
            res_entry <= '0;
            found     <= 1'b0;
            proc_idx  <= (cmd.action == epq_pkg::ACT_INSERT) ?
                         epq_pkg::IDX_W'(count - epq_pkg::CNT_W'(1)) : '0;
            case (cmd.action)
              epq_pkg::ACT_INSERT: begin
                if (full) begin
                  res_status <= epq_pkg::STAT_FULL;
                end else begin
                  res_status <= epq_pkg::STAT_OK;
                  if (empty) begin
                    count <= count + epq_pkg::CNT_W'(1);
                  end
                end
              end
              epq_pkg::ACT_POP: begin
                res_status <= empty ? epq_pkg::STAT_EMPTY : epq_pkg::STAT_OK;
              end
              epq_pkg::ACT_DELETE: begin
                res_status <= empty ? epq_pkg::STAT_NOTFOUND : epq_pkg::STAT_OK;
              end
              default: res_status <= epq_pkg::STAT_OK;
            endcase
          end
        end
        epq_pkg::S_SCAN: begin
          if (op_insert) begin
            if (greater) begin
              proc_idx <= proc_idx - epq_pkg::IDX_W'(1);
            end else begin
              count <= count + epq_pkg::CNT_W'(1);
            end
          end else begin
            if (!found && hit) begin
              found     <= 1'b1;
              res_entry <= rd_data;
            end
            proc_idx <= proc_idx + epq_pkg::IDX_W'(1);
            if (last) begin
              if (found || hit) begin
                count <= count - epq_pkg::CNT_W'(1);
              end else begin
                res_status <= epq_pkg::STAT_NOTFOUND;
              end
            end
          end
        end
        epq_pkg::S_PLACE: begin
          count <= count + epq_pkg::CNT_W'(1);
        end
        epq_pkg::S_FINISH: begin
          found <= found;
        end
        default: found <= found;
      endcase
    end
  end

  // Result handoff
  assign idle      = (state == epq_pkg::S_IDLE);
  assign res_valid = (state == epq_pkg::S_FINISH) && slot_free;
  assign res       = '{status: res_status, entry: res_entry,
                       occupancy: epq_pkg::OCC_W'(count)};

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= epq_pkg::CNT_W'(epq_pkg::QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == epq_pkg::S_SCAN |-> epq_pkg::CNT_W'(proc_idx) < count)
    else $error("walk index outside stored entries");

  a_write_contiguous: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> epq_pkg::CNT_W'(wr_addr) <= count)
    else $error("store write leaves a gap");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == epq_pkg::STAT_EMPTY |-> count == '0)
    else $error("empty reported with entries stored");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == epq_pkg::STAT_FULL |->
      count == epq_pkg::CNT_W'(epq_pkg::QUEUE_DEPTH))
    else $error("full reported below depth");

endmodule

### hw/rtl/event_priority_queue.sv
// Top level of the event priority queue: channels, sequencer and output register.
// An item is one insert, pop or delete on a queue of up to QUEUE_DEPTH events kept
// sorted by arrival time, earliest first, equal times in arrival order. The store
// is a memory with one write and one registered read port, walked one entry per
// cycle: an insert walks down from the tail past every stored entry with a later
// time, and a pop or delete walks every stored entry from the head. QUEUE_DEPTH
// is 16 by default. Inserts into a full queue, unused action codes and operations
// on an empty queue finish without a walk. The last cycle of an item repeats while
// the output register still holds an untaken result. The input is ready only while
// no item is in progress; a finished result sits in an output register, so a new
// item may be accepted while it waits to be taken.
module event_priority_queue (
  input  logic      clk,
  input  logic      rst,
  epq_in_if.sink    cmd,
  epq_out_if.source rsp
);

  logic             core_idle;
  logic             start;
  logic             slot_free;
  logic             res_valid;
  epq_pkg::cmd_t    core_cmd;
  epq_pkg::result_t res;
  epq_pkg::result_t out_res;
  logic             out_valid;

  assign cmd.ready = core_idle;
  assign start     = cmd.valid && core_idle;
  assign core_cmd  = '{action: cmd.action, key: cmd.arr_stamp,
                       ev: '{io_time: cmd.io_time, cpu_burst: cmd.cpu_burst,
                             pid: cmd.pid}};

  epq_core u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (core_cmd),
    .slot_free (slot_free),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register
  assign slot_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_res.status;
  assign rsp.out_pid       = out_res.entry.ev.pid;
  assign rsp.out_arr_stamp = out_res.entry.key;
  assign rsp.out_cpu_burst = out_res.entry.ev.cpu_burst;
  assign rsp.out_io_time   = out_res.entry.ev.io_time;
  assign rsp.occupancy     = out_res.occupancy;

endmodule
